// ===== hdl/lcdwr_pkg.sv =====
// Shared types and constants for the character LCD text wrap writer.
// It depends on nothing. The emitter and the top level both import it.
`timescale 1ns / 1ps

package lcdwr_pkg;

  // Default geometry of the display: characters per line, and the spaces
  // written to blank a line.
  localparam int LINE_CHARS_DEF   = 16;
  localparam int CLEAR_SPACES_DEF = 17;

  // Controller instruction bytes and the blank character.
  localparam logic [7:0] CMD_LINE_TWO = 8'hC0;
  localparam logic [7:0] CMD_LINE_ONE = 8'h80;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;

  // Register select codes on the controller bus.
  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  // The wrap burst, if any, that comes before a character.
  typedef enum logic [1:0] {
    WRAP_NONE,
    WRAP_FROM_ONE,
    WRAP_FROM_TWO
  } wrap_kind_t;

  // One input item.
  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } in_item_t;

  // One bus write.
  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last_write;
  } out_item_t;

  // A character with its wrap decision, handed to the emitter.
  typedef struct packed {
    logic [7:0] char_code;
    wrap_kind_t wrap;
  } job_t;

endpackage

// ===== hdl/char_lcd_text_wrap_writer_top.sv =====
// Top level of the character LCD text wrap writer: cursor tracking and emitter.
// It depends on lcdwr_pkg and instantiates lcdwr_emitter.
//
//   channel  direction  ports                          moves
//   in       input      in_valid, in_stall, in_item    one character item
//   out      output     out_valid, out_stall, out_item one bus write item
//
// A character without a wrap is a single write, so items stream at one per cycle
// while the output does not stall. A wrap holds the input while the emitter's step
// counter walks line commands, CLEAR_SPACES spaces and, from line two, a clear.
// Reset clears the column count, the line flag and all valid flags.
// A stall on the output holds its register; the job register then fills and
// the input stalls until the held write drains and the character write is taken.
`timescale 1ns / 1ps

module char_lcd_text_wrap_writer_top #(
  parameter int LINE_CHARS   = lcdwr_pkg::LINE_CHARS_DEF,
  parameter int CLEAR_SPACES = lcdwr_pkg::CLEAR_SPACES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lcdwr_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lcdwr_pkg::out_item_t  out_item
);
  import lcdwr_pkg::*;

  localparam int COL_W = $clog2(LINE_CHARS + 1);
  localparam logic [COL_W-1:0] LINE_FULL = COL_W'(LINE_CHARS);

  logic [COL_W-1:0] column_r;
  logic [COL_W-1:0] column_nxt;
  logic             line_two_r;
  logic             line_two_nxt;
  logic [COL_W-1:0] col_eff;
  logic             line_eff;
  logic             wrap;
  logic             accept;
  job_t             job;

  assign accept = in_valid && !in_stall;

  // A string mark clears the cursor before the character is placed.
  always_comb begin
    col_eff  = in_item.string_start ? '0 : column_r;
    line_eff = in_item.string_start ? 1'b0 : line_two_r;
    wrap     = (col_eff >= LINE_FULL);
    column_nxt   = (wrap ? '0 : col_eff) + 1'b1;
    line_two_nxt = wrap ? !line_eff : line_eff;
    job.char_code = in_item.char_code;
    if (!wrap) begin
      job.wrap = WRAP_NONE;
    end else if (line_eff) begin
      job.wrap = WRAP_FROM_TWO;
    end else begin
      job.wrap = WRAP_FROM_ONE;
    end
  end

  // Cursor state advances when a character item is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      line_two_r <= 1'b0;
    end else if (accept) begin
      column_r   <= column_nxt;
      line_two_r <= line_two_nxt;
    end
  end

  lcdwr_emitter #(
    .CLEAR_SPACES(CLEAR_SPACES)
  ) u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(in_valid),
    .job      (job),
    .job_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

// ===== hdl/lcdwr_emitter.sv =====
// Bus write emitter: holds one character job and steps through its wrap burst.
// It depends on lcdwr_pkg for the job and write types and the command bytes.
`timescale 1ns / 1ps

module lcdwr_emitter #(
  parameter int CLEAR_SPACES = lcdwr_pkg::CLEAR_SPACES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  input  lcdwr_pkg::job_t       job,
  output logic                  job_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lcdwr_pkg::out_item_t  out_item
);
  import lcdwr_pkg::*;

  localparam int STEP_W = $clog2(CLEAR_SPACES + 4);
  localparam logic [STEP_W-1:0] LAST_SPACE = STEP_W'(CLEAR_SPACES);
  localparam logic [STEP_W-1:0] STEP_CMD_A = STEP_W'(CLEAR_SPACES + 1);
  localparam logic [STEP_W-1:0] STEP_CMD_B = STEP_W'(CLEAR_SPACES + 2);

  logic              job_valid_r;
  job_t              job_r;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              out_valid_r;
  out_item_t         out_item_r;
  out_item_t         cur_write;
  out_item_t         char_write;
  logic              advance;
  logic              retire;

  // The output register can take a new write when empty or being drained.
  assign advance = !out_valid_r || !out_stall;
  assign retire  = job_valid_r && advance && cur_write.last_write;
  assign job_stall = job_valid_r && !retire;

  // Write for the current step of the held job.
  always_comb begin
    char_write = '{reg_select: RS_DATA, bus_byte: job_r.char_code, last_write: 1'b1};
    cur_write  = char_write;
    case (job_r.wrap)
      WRAP_NONE: begin
        cur_write = char_write;
      end
      WRAP_FROM_ONE: begin
        if (step_r == '0) begin
          cur_write = '{reg_select: RS_INSTR, bus_byte: CMD_LINE_TWO, last_write: 1'b0};
        end else if (step_r <= LAST_SPACE) begin
          cur_write = '{reg_select: RS_DATA, bus_byte: SPACE_CHAR, last_write: 1'b0};
        end else if (step_r == STEP_CMD_A) begin
          cur_write = '{reg_select: RS_INSTR, bus_byte: CMD_LINE_TWO, last_write: 1'b0};
        end else begin
          cur_write = char_write;
        end
      end
      WRAP_FROM_TWO: begin
        if (step_r == '0) begin
          cur_write = '{reg_select: RS_INSTR, bus_byte: CMD_LINE_ONE, last_write: 1'b0};
        end else if (step_r <= LAST_SPACE) begin
          cur_write = '{reg_select: RS_DATA, bus_byte: SPACE_CHAR, last_write: 1'b0};
        end else if (step_r == STEP_CMD_A) begin
          cur_write = '{reg_select: RS_INSTR, bus_byte: CMD_LINE_TWO, last_write: 1'b0};
        end else if (step_r == STEP_CMD_B) begin
          cur_write = '{reg_select: RS_INSTR, bus_byte: CMD_CLEAR, last_write: 1'b0};
        end else begin
          cur_write = char_write;
        end
      end
      default: begin
        cur_write = char_write;
      end
    endcase
  end

  // Step counter returns to zero when the character itself goes out.
  always_comb begin
    step_nxt = step_r;
    if (job_valid_r && advance) begin
      step_nxt = cur_write.last_write ? '0 : step_r + 1'b1;
    end
  end

  // Control state: job occupancy, step and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (advance) begin
        out_valid_r <= job_valid_r;
      end
      if (job_valid && !job_stall) begin
        job_valid_r <= 1'b1;
      end else if (retire) begin
        job_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (job_valid && !job_stall) begin
      job_r <= job;
    end
    if (advance && job_valid_r) begin
      out_item_r <= cur_write;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
